>>> hw/rtl/pcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_CLASSES = 4;
  localparam int TAG_BITS    = 8;

  localparam int CLS_W  = 2;
  localparam int ACT_W  = 2;
  localparam int PRIO_W = 4;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0]  PRIO_RST  = 16'h0000;
  localparam logic [CFG_W-1:0]  LIMIT_RST = 16'h1111;
  localparam logic [PRIO_W:0]   PRIO_NONE = {1'b1, {PRIO_W{1'b0}}};
  localparam logic [PRIO_W-1:0] RUN_MAX   = {PRIO_W{1'b1}};

  typedef enum logic [ACT_W-1:0] {
    ACT_ENQ    = 2'd0,
    ACT_FIN    = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_OK     = 2'd1,
    ST_DENIED = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    REG_PRIO  = 1'b0,
    REG_LIMIT = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [CLS_W-1:0]    req_class;
    logic [TAG_BITS-1:0] req_tag;
    logic                url_allowed;
  } in_item_t;

  typedef struct packed {
    logic                start_valid;
    logic [TAG_BITS-1:0] start_tag;
    logic [CLS_W-1:0]    start_class;
    logic [1:0]          enqueue_status;
  } out_item_t;

  typedef struct packed {
    logic [CLS_W-1:0]    cls;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic             fin_vld;
    logic [CLS_W-1:0] fin_cls;
    logic             inc_vld;
    logic [CLS_W-1:0] inc_cls;
  } cls_upd_t;

  function automatic logic cls_ok(logic [CLS_W-1:0] c);
    return (32'(c) < NUM_CLASSES);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pcs_cls.sv
`timescale 1ns / 1ps
`default_nettype none

module pcs_cls (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [pcs_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  wire pcs_pkg::cls_upd_t               upd_i,
  input  wire logic [pcs_pkg::CLS_W-1:0]       qry_cls_i,
  output logic [pcs_pkg::PRIO_W-1:0]           qry_prio_o,
  output logic                                 qry_elig_o
);

  logic [pcs_pkg::CFG_W-1:0]  prio_q;
  logic [pcs_pkg::CFG_W-1:0]  limit_q;
  logic [pcs_pkg::PRIO_W-1:0] run_q [pcs_pkg::NUM_CLASSES];
  logic [pcs_pkg::PRIO_W-1:0] run_d [pcs_pkg::NUM_CLASSES];
  logic [pcs_pkg::NUM_CLASSES-1:0] elig;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q  <= pcs_pkg::PRIO_RST;
      limit_q <= pcs_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (pcs_pkg::reg_e'(cfg_idx_i))
        pcs_pkg::REG_PRIO:  prio_q  <= cfg_wdata_i;
        pcs_pkg::REG_LIMIT: limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int c = 0; c < pcs_pkg::NUM_CLASSES; c++) begin
      run_d[c] = run_q[c];
      if (upd_i.fin_vld && upd_i.fin_cls == pcs_pkg::CLS_W'(c) && run_q[c] != '0) begin
        run_d[c] = run_q[c] - 1'b1;
      end else if (upd_i.inc_vld && upd_i.inc_cls == pcs_pkg::CLS_W'(c) &&
                   run_q[c] != pcs_pkg::RUN_MAX) begin
        run_d[c] = run_q[c] + 1'b1;
      end
      elig[c] = run_q[c] < limit_q[c*pcs_pkg::PRIO_W +: pcs_pkg::PRIO_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < pcs_pkg::NUM_CLASSES; c++) begin
        run_q[c] <= '0;
      end
    end else begin
      for (int c = 0; c < pcs_pkg::NUM_CLASSES; c++) begin
        run_q[c] <= run_d[c];
      end
    end
  end

  assign qry_elig_o = elig[qry_cls_i];
  assign qry_prio_o = prio_q[qry_cls_i*pcs_pkg::PRIO_W +: pcs_pkg::PRIO_W];

endmodule

`default_nettype wire

>>> hw/rtl/pcs_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module pcs_seq (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire pcs_pkg::in_item_t           in_item_i,
  output logic                             res_vld_o,
  output pcs_pkg::out_item_t               res_o,
  output pcs_pkg::cls_upd_t                upd_o,
  output logic [pcs_pkg::CLS_W-1:0]        qry_cls_o,
  input  wire logic [pcs_pkg::PRIO_W-1:0]  qry_prio_i,
  input  wire logic                        qry_elig_i
);

  pcs_pkg::state_e  state_q, state_d;
  pcs_pkg::status_e status_q, status_d;
  logic [pcs_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [pcs_pkg::CNT_W-1:0]  idx_q, idx_d;
  logic [pcs_pkg::CNT_W-1:0]  nxt;
  logic                       cmp_vld_q, cmp_vld_d;
  logic [pcs_pkg::IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic                       found_q, found_d;
  logic [pcs_pkg::PRIO_W:0]   best_prio_q, best_prio_d;
  logic [pcs_pkg::IDX_W-1:0]  best_idx_q, best_idx_d;
  pcs_pkg::entry_t            best_ent_q, best_ent_d;
  logic                       wr_vld_q, wr_vld_d;
  logic [pcs_pkg::IDX_W-1:0]  wr_addr_q, wr_addr_d;
  logic                       res_vld_q, res_vld_d;
  pcs_pkg::out_item_t         res_q, res_d;
  logic                       accept;
  logic                       hit;

  pcs_pkg::entry_t            mem_q [pcs_pkg::QUEUE_DEPTH];
  pcs_pkg::entry_t            mem_rdata_q;
  logic                       mem_we;
  logic [pcs_pkg::IDX_W-1:0]  mem_waddr;
  pcs_pkg::entry_t            mem_wdata;
  logic                       mem_re;
  logic [pcs_pkg::IDX_W-1:0]  mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  assign accept    = start && !busy;
  assign busy      = state_q != pcs_pkg::S_IDLE;
  assign qry_cls_o = mem_rdata_q.cls;
  assign nxt       = idx_q + 1'b1;
  assign hit       = cmp_vld_q && pcs_pkg::cls_ok(mem_rdata_q.cls) && qry_elig_i &&
                     ({1'b0, qry_prio_i} < best_prio_q);

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    best_prio_d = best_prio_q;
    best_idx_d  = best_idx_q;
    best_ent_d  = best_ent_q;
    wr_vld_d    = 1'b0;
    wr_addr_d   = wr_addr_q;
    res_vld_d   = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    upd_o       = '0;

    unique case (state_q)
      pcs_pkg::S_IDLE: begin
        if (accept) begin
          status_d    = pcs_pkg::ST_NONE;
          idx_d       = '0;
          found_d     = 1'b0;
          best_prio_d = pcs_pkg::PRIO_NONE;
          state_d     = pcs_pkg::S_SCAN;
          unique case (pcs_pkg::action_e'(in_item_i.action))
            pcs_pkg::ACT_ENQ: begin
              if (!in_item_i.url_allowed || !pcs_pkg::cls_ok(in_item_i.req_class)) begin
                status_d = pcs_pkg::ST_DENIED;
              end else if (32'(cnt_q) >= pcs_pkg::QUEUE_DEPTH) begin
                status_d = pcs_pkg::ST_FULL;
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = cnt_q[pcs_pkg::IDX_W-1:0];
                mem_wdata.cls = in_item_i.req_class;
                mem_wdata.tag = in_item_i.req_tag;
                cnt_d         = cnt_q + 1'b1;
                status_d      = pcs_pkg::ST_OK;
              end
            end
            pcs_pkg::ACT_FIN: begin
              upd_o.fin_vld = pcs_pkg::cls_ok(in_item_i.req_class);
              upd_o.fin_cls = in_item_i.req_class;
            end
            pcs_pkg::ACT_CANCEL: begin
              cnt_d = '0;
            end
            pcs_pkg::ACT_NONE: ;
            default: ;
          endcase
        end
      end

      pcs_pkg::S_SCAN: begin
        if (idx_q < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[pcs_pkg::IDX_W-1:0];
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[pcs_pkg::IDX_W-1:0];
          idx_d     = nxt;
        end
        if (hit) begin
          found_d     = 1'b1;
          best_prio_d = {1'b0, qry_prio_i};
          best_idx_d  = cmp_idx_q;
          best_ent_d  = mem_rdata_q;
        end
        if (idx_q == cnt_q && !cmp_vld_q) begin
          if (found_q) begin
            idx_d   = pcs_pkg::CNT_W'(best_idx_q);
            state_d = pcs_pkg::S_SHIFT;
          end else begin
            res_d.start_valid    = 1'b0;
            res_d.start_tag      = '0;
            res_d.start_class    = '0;
            res_d.enqueue_status = status_q;
            res_vld_d            = 1'b1;
            state_d              = pcs_pkg::S_IDLE;
          end
        end
      end

      pcs_pkg::S_SHIFT: begin
        if (nxt < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = nxt[pcs_pkg::IDX_W-1:0];
          wr_vld_d  = 1'b1;
          wr_addr_d = idx_q[pcs_pkg::IDX_W-1:0];
          idx_d     = nxt;
        end
        if (wr_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_q;
          mem_wdata = mem_rdata_q;
        end
        if (!(nxt < cnt_q) && !wr_vld_q) begin
          cnt_d                = cnt_q - 1'b1;
          upd_o.inc_vld        = 1'b1;
          upd_o.inc_cls        = best_ent_q.cls;
          res_d.start_valid    = 1'b1;
          res_d.start_tag      = best_ent_q.tag;
          res_d.start_class    = best_ent_q.cls;
          res_d.enqueue_status = status_q;
          res_vld_d            = 1'b1;
          state_d              = pcs_pkg::S_IDLE;
        end
      end

      default: state_d = pcs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pcs_pkg::S_IDLE;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      wr_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      wr_vld_q  <= wr_vld_d;
      found_q   <= found_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    idx_q       <= idx_d;
    cmp_idx_q   <= cmp_idx_d;
    best_prio_q <= best_prio_d;
    best_idx_q  <= best_idx_d;
    best_ent_q  <= best_ent_d;
    wr_addr_q   <= wr_addr_d;
    res_q       <= res_d;
  end

  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= pcs_pkg::QUEUE_DEPTH)
    else $error("pending count above table depth");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (pcs_pkg::CNT_W'(mem_raddr) < cnt_q))
    else $error("read of an entry outside the pending table");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == pcs_pkg::S_SCAN && !res_vld_o))
    else $error("accepted item did not enter the scan");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o |=> !res_vld_o)
    else $error("result strobe held for more than one cycle");

  a_shift_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcs_pkg::S_SHIFT) |-> (found_q && cnt_q != '0))
    else $error("compaction without a selected entry");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/priority_class_concurrency_scheduler.sv
// The result strobe comes after a scan of the pending entries when nothing starts, and after
// the scan and a compaction of the table when an entry starts; scan and compaction move one
// entry per cycle through the pending memory, which has one read port and one write port.
// The scheduler takes no new item while busy; busy drops in the cycle the result is shown.
// The result is shown for one cycle and cannot be stalled by the receiver.
// Reset empties the pending table, clears the running counts and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module priority_class_concurrency_scheduler (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire pcs_pkg::in_item_t          in_item_i,
  output logic                            res_vld_o,
  output pcs_pkg::out_item_t              res_o,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [pcs_pkg::CFG_W-1:0]  cfg_wdata_i
);

  pcs_pkg::cls_upd_t           upd;
  logic [pcs_pkg::CLS_W-1:0]   qry_cls;
  logic [pcs_pkg::PRIO_W-1:0]  qry_prio;
  logic                        qry_elig;

  pcs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_item_i  (in_item_i),
    .res_vld_o  (res_vld_o),
    .res_o      (res_o),
    .upd_o      (upd),
    .qry_cls_o  (qry_cls),
    .qry_prio_i (qry_prio),
    .qry_elig_i (qry_elig)
  );

  pcs_cls u_cls (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .upd_i       (upd),
    .qry_cls_i   (qry_cls),
    .qry_prio_o  (qry_prio),
    .qry_elig_o  (qry_elig)
  );

endmodule

`default_nettype wire

>>> tb/pcs_sched_checker.sv
`timescale 1ns / 1ps

module pcs_sched_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  pcs_pkg::in_item_t         item_i,
  input  logic                      res_vld_i,
  input  pcs_pkg::out_item_t        res_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [pcs_pkg::CFG_W-1:0] cfg_wdata_i,
  output int                        fails_o,
  output int                        left_o,
  output int                        starts_o,
  output int                        fulls_o
);
  import pcs_pkg::*;

  logic [CFG_W-1:0]  prio_reg;
  logic [CFG_W-1:0]  limit_reg;
  entry_t            waiting[$];
  logic [PRIO_W-1:0] running [NUM_CLASSES];
  out_item_t         due[$];
  int                fails = 0;
  int                left = 0;
  int                starts = 0;
  int                fulls = 0;

  assign fails_o  = fails;
  assign left_o   = left;
  assign starts_o = starts;
  assign fulls_o  = fulls;

  function automatic out_item_t schedule_item(in_item_t it);
    out_item_t         res;
    entry_t            ent;
    int                pick;
    logic [PRIO_W:0]   best;
    logic [PRIO_W-1:0] lim;
    logic [PRIO_W-1:0] pr;
    res  = '0;
    pick = -1;
    best = PRIO_NONE;
    case (action_e'(it.action))
      ACT_ENQ: begin
        if (!it.url_allowed || int'(it.req_class) >= NUM_CLASSES) begin
          res.enqueue_status = ST_DENIED;
        end else if (waiting.size() >= QUEUE_DEPTH) begin
          res.enqueue_status = ST_FULL;
        end else begin
          ent.cls = it.req_class;
          ent.tag = it.req_tag;
          waiting.push_back(ent);
          res.enqueue_status = ST_OK;
        end
      end
      ACT_FIN: begin
        if (int'(it.req_class) < NUM_CLASSES && running[it.req_class] != 0)
          running[it.req_class] = running[it.req_class] - 1'b1;
      end
      ACT_CANCEL: begin
        waiting.delete();
      end
      default: ;
    endcase
    foreach (waiting[i]) begin
      lim = limit_reg[waiting[i].cls * PRIO_W +: PRIO_W];
      pr  = prio_reg[waiting[i].cls * PRIO_W +: PRIO_W];
      if (running[waiting[i].cls] < lim && {1'b0, pr} < best) begin
        best = {1'b0, pr};
        pick = i;
      end
    end
    if (pick >= 0) begin
      ent = waiting[pick];
      waiting.delete(pick);
      if (running[ent.cls] != RUN_MAX)
        running[ent.cls] = running[ent.cls] + 1'b1;
      res.start_valid = 1'b1;
      res.start_tag   = ent.tag;
      res.start_class = ent.cls;
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fails++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      prio_reg  = PRIO_RST;
      limit_reg = LIMIT_RST;
      waiting.delete();
      due.delete();
      foreach (running[c]) running[c] = '0;
    end else begin
      if (cfg_we_i) begin
        if (reg_e'(cfg_idx_i) == REG_PRIO) prio_reg = cfg_wdata_i;
        else limit_reg = cfg_wdata_i;
      end
      if (res_vld_i) begin
        if (due.size() == 0) begin
          fails++;
          $error("result with no item outstanding: %p", res_i);
        end else begin
          want = due.pop_front();
          check_field("start_valid", 16'(want.start_valid), 16'(res_i.start_valid));
          check_field("start_tag", 16'(want.start_tag), 16'(res_i.start_tag));
          check_field("start_class", 16'(want.start_class), 16'(res_i.start_class));
          check_field("enqueue_status", 16'(want.enqueue_status),
                      16'(res_i.enqueue_status));
        end
      end
      if (start_i && !busy_i) begin
        want = schedule_item(item_i);
        if (want.start_valid) starts++;
        if (want.enqueue_status == ST_FULL) fulls++;
        due.push_back(want);
      end
    end
    left = due.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import pcs_pkg::*;

  localparam int NUM_PHASES     = 5;
  localparam int ITEMS_PER_PASS = 185;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_item_t         in_item = '0;
  logic             res_vld;
  out_item_t        res;
  logic             cfg_we = 1'b0;
  logic             cfg_idx = REG_PRIO;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int               fails;
  int               left;
  int               starts;
  int               fulls;
  int               sent = 0;

  logic [CFG_W-1:0] prio_set  [NUM_PHASES] = '{16'h0000, 16'hFFFF, 16'h3210, 16'h0000, 16'h0123};
  logic [CFG_W-1:0] limit_set [NUM_PHASES] = '{16'h1111, 16'h0000, 16'hFFFF, 16'h0000, 16'h2031};
  int               idle_set  [NUM_PHASES] = '{0, 80, 0, 26, 80};

  priority_class_concurrency_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_item_i   (in_item),
    .res_vld_o   (res_vld),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  pcs_sched_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (in_item),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .fails_o     (fails),
    .left_o      (left),
    .starts_o    (starts),
    .fulls_o     (fulls)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic in_item_t mk(action_e act, int cls, int tag, bit ok);
    in_item_t it;
    it.action      = act;
    it.req_class   = CLS_W'(cls);
    it.req_tag     = TAG_BITS'(tag);
    it.url_allowed = ok;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    int r;
    action_e act;
    r = $urandom_range(99);
    if (r < 55) act = ACT_ENQ;
    else if (r < 88) act = ACT_FIN;
    else if (r < 95) act = ACT_NONE;
    else act = ACT_CANCEL;
    return mk(act, $urandom_range(3), $urandom_range(255), $urandom_range(9) != 0);
  endfunction

  task automatic send_item(in_item_t it, int gap);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (busy);
    sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(reg_e idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (left != 0);
    repeat (2) @(posedge clk_i);
  endtask

  initial begin
    in_item_t directed[$];
    int gap;
    directed.push_back(mk(ACT_ENQ, 0, 'h00, 1'b1));
    directed.push_back(mk(ACT_ENQ, 0, 'hFF, 1'b1));
    directed.push_back(mk(ACT_ENQ, 1, 'h5A, 1'b1));
    directed.push_back(mk(ACT_ENQ, 2, 'h33, 1'b0));
    directed.push_back(mk(ACT_ENQ, 3, 'hC3, 1'b1));
    directed.push_back(mk(ACT_NONE, 1, 'hA5, 1'b1));
    directed.push_back(mk(ACT_FIN, 0, 'h00, 1'b0));
    directed.push_back(mk(ACT_FIN, 2, 'h00, 1'b0));
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      directed.push_back(mk(ACT_ENQ, 1, 16 * i + 1, 1'b1));
    directed.push_back(mk(ACT_FIN, 1, 'h00, 1'b1));
    directed.push_back(mk(ACT_CANCEL, 3, 'h00, 1'b1));
    prio_set[3]  = CFG_W'($urandom_range(16'hFFFF));
    limit_set[3] = CFG_W'($urandom_range(16'hFFFF));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_PRIO, prio_set[p]);
      write_reg(REG_LIMIT, limit_set[p]);
      if (p == 0) begin
        foreach (directed[i]) send_item(directed[i], 0);
      end
      repeat (ITEMS_PER_PASS) begin
        gap = ($urandom_range(99) < idle_set[p]) ? $urandom_range(1, 40) : 0;
        send_item(rand_item(), gap);
      end
      start <= 1'b0;
      wait_idle();
    end

    repeat (40) @(posedge clk_i);
    $display("Drove %0d items through %0d register settings with idle mixes of 0, 26 and 80.",
             sent, NUM_PHASES);
    $display("The scheduler started %0d requests and turned %0d away on a full table.",
             starts, fulls);
    if (fails == 0 && left == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/pcs_pkg.sv
hw/rtl/pcs_cls.sv
hw/rtl/pcs_seq.sv
hw/rtl/priority_class_concurrency_scheduler.sv
tb/pcs_sched_checker.sv
tb/tb.sv
